/* hw/rtl/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Constants, sector codes and fixed-point widths shared by the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // input field widths
  localparam int unsigned IndexW = 8;
  localparam int unsigned HueW   = 13;
  localparam int unsigned FracW  = 8;
  localparam int unsigned ChanW  = 8;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InBits   = IndexW + HueW + FracW + FracW;
  localparam int unsigned InDataW  = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits  = IndexW + 3 * ChanW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // hue sectors and fixed-point scales
  localparam int unsigned SectorSpan   = 960;
  localparam int unsigned FullScale    = 255;
  localparam int unsigned SectorCount  = 6;
  localparam int unsigned ProductScale = SectorSpan * FullScale;
  localparam int unsigned MaxQuot      = 8;  // largest hue / 960 for a 13-bit hue

  localparam int unsigned QuotW = 4;
  localparam int unsigned RemW  = 10;
  localparam int unsigned AW    = 18;  // holds ProductScale
  localparam int unsigned XW    = 26;  // brightness times AW term

  // exact division by ProductScale through a reciprocal, valid for XW-bit operands
  localparam int unsigned RecipShift = 44;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecipShift) + 64'(ProductScale) - 64'd1) / 64'(ProductScale);
  localparam int unsigned RecipW = 27;
  localparam logic [RecipW-1:0] RecipMult = RecipFull[RecipW-1:0];
  localparam int unsigned ProdW = XW + RecipW;

  localparam int unsigned LedLimitDefault = 256;

  // channel slots of the three derived terms
  localparam int unsigned ChP = 0;
  localparam int unsigned ChQ = 1;
  localparam int unsigned ChT = 2;
  localparam int unsigned NumCh = 3;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

endpackage

/* hw/rtl/hsv_to_rgb_converter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Pipelined HSV to RGB conversion of a stream of LED colour requests, with
// truncating fixed-point arithmetic throughout.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (lsb first)
//  s_axis    in         led_index[7:0] hue[20:8] saturation[28:21]
//                       brightness[36:29] zero pad[39:37]
//  m_axis    out        out_index[7:0] red[15:8] green[23:16] blue[31:24]
//
//  one request a cycle is taken and one result a cycle is returned while
//  m_axis does not stall; the register stages are, in order: sector split,
//  term forming, brightness multiply, reciprocal multiply, channel select.
//  reset clears only the stage valid bits.
//  each stage holds when it is full and its successor stalls, so a stall on
//  m_axis fills the stages one by one before s_axis_tready_o falls.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core #(
  parameter int unsigned LED_LIMIT = hsv2rgb_pkg::LedLimitDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // led_index, hue, saturation, brightness
  input  logic [hsv2rgb_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_index, red, green, blue
  output logic [hsv2rgb_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = hsv2rgb_pkg::IndexW;
  localparam int unsigned HW   = hsv2rgb_pkg::HueW;
  localparam int unsigned FW   = hsv2rgb_pkg::FracW;
  localparam int unsigned CW   = hsv2rgb_pkg::ChanW;
  localparam int unsigned QW   = hsv2rgb_pkg::QuotW;
  localparam int unsigned RW   = hsv2rgb_pkg::RemW;
  localparam int unsigned AW   = hsv2rgb_pkg::AW;
  localparam int unsigned XW   = hsv2rgb_pkg::XW;
  localparam int unsigned PW   = hsv2rgb_pkg::ProdW;
  localparam int unsigned NC   = hsv2rgb_pkg::NumCh;
  localparam int unsigned IdxN = 1 << IdxW;

  // input fields
  logic [IdxW-1:0] in_index;
  logic [HW-1:0]   in_hue;
  logic [FW-1:0]   in_sat;
  logic [FW-1:0]   in_val;

  assign in_index = s_axis_tdata_i[IdxW-1:0];
  assign in_hue   = s_axis_tdata_i[IdxW+HW-1:IdxW];
  assign in_sat   = s_axis_tdata_i[IdxW+HW+FW-1:IdxW+HW];
  assign in_val   = s_axis_tdata_i[IdxW+HW+2*FW-1:IdxW+HW+FW];

  // stage handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_en, s2_en, s3_en, s4_en, out_en;

  assign out_en = ~out_valid_q | m_axis_tready_i;
  assign s4_en  = ~s4_valid_q | out_en;
  assign s3_en  = ~s3_valid_q | s4_en;
  assign s2_en  = ~s2_valid_q | s3_en;
  assign s1_en  = ~s1_valid_q | s2_en;
  assign s_axis_tready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= s_axis_tvalid_i;
      if (s2_en)  s2_valid_q  <= s1_valid_q;
      if (s3_en)  s3_valid_q  <= s2_valid_q;
      if (s4_en)  s4_valid_q  <= s3_valid_q;
      if (out_en) out_valid_q <= s4_valid_q;
    end
  end

  // index wrap table, folded to constants
  logic [IdxW-1:0] idx_mod_tbl [IdxN];

  always_comb begin
    for (int i = 0; i < IdxN; i++) begin
      idx_mod_tbl[i] = IdxW'(i % LED_LIMIT);
    end
  end

  // stage 1: sector number and remainder within the sector
  logic [QW-1:0]       quot;
  logic [HW-1:0]       hue_base;
  logic [RW-1:0]       s1_rem_d;
  hsv2rgb_pkg::sector_e s1_sec_d;

  always_comb begin
    quot = '0;
    for (int j = 1; j <= hsv2rgb_pkg::MaxQuot; j++) begin
      if (in_hue >= HW'(j * hsv2rgb_pkg::SectorSpan)) quot = QW'(j);
    end
    hue_base = HW'(quot) * HW'(hsv2rgb_pkg::SectorSpan);
    s1_rem_d = RW'(in_hue - hue_base);
    // hues past the circle wrap back to the first sectors
    if (quot >= QW'(hsv2rgb_pkg::SectorCount)) begin
      s1_sec_d = hsv2rgb_pkg::sector_e'(3'(quot - QW'(hsv2rgb_pkg::SectorCount)));
    end else begin
      s1_sec_d = hsv2rgb_pkg::sector_e'(3'(quot));
    end
  end

  logic [IdxW-1:0]      s1_index_q;
  logic [RW-1:0]        s1_rem_q;
  logic [FW-1:0]        s1_sat_q;
  logic [FW-1:0]        s1_val_q;
  hsv2rgb_pkg::sector_e s1_sec_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_index_q <= idx_mod_tbl[in_index];
      s1_rem_q   <= s1_rem_d;
      s1_sat_q   <= in_sat;
      s1_val_q   <= in_val;
      s1_sec_q   <= s1_sec_d;
    end
  end

  // stage 2: numerators of p, q and t over the common scale 960 * 255
  logic [AW-1:0] s2_a_d [NC];
  logic [AW-1:0] rs_prod, rcs_prod;
  logic [RW-1:0] rem_c;

  always_comb begin
    rem_c    = RW'(hsv2rgb_pkg::SectorSpan) - s1_rem_q;
    rs_prod  = AW'(s1_rem_q) * AW'(s1_sat_q);
    rcs_prod = AW'(rem_c) * AW'(s1_sat_q);
    s2_a_d[hsv2rgb_pkg::ChP] = AW'(hsv2rgb_pkg::SectorSpan) *
                               (AW'(hsv2rgb_pkg::FullScale) - AW'(s1_sat_q));
    s2_a_d[hsv2rgb_pkg::ChQ] = AW'(hsv2rgb_pkg::ProductScale) - rs_prod;
    s2_a_d[hsv2rgb_pkg::ChT] = AW'(hsv2rgb_pkg::ProductScale) - rcs_prod;
  end

  logic [IdxW-1:0]      s2_index_q;
  logic [FW-1:0]        s2_val_q;
  hsv2rgb_pkg::sector_e s2_sec_q;
  logic [AW-1:0]        s2_a_q [NC];

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_index_q <= s1_index_q;
      s2_val_q   <= s1_val_q;
      s2_sec_q   <= s1_sec_q;
      for (int c = 0; c < NC; c++) s2_a_q[c] <= s2_a_d[c];
    end
  end

  // stage 3: scale by brightness
  logic [IdxW-1:0]      s3_index_q;
  logic [FW-1:0]        s3_val_q;
  hsv2rgb_pkg::sector_e s3_sec_q;
  logic [XW-1:0]        s3_x_q [NC];

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_index_q <= s2_index_q;
      s3_val_q   <= s2_val_q;
      s3_sec_q   <= s2_sec_q;
      for (int c = 0; c < NC; c++) s3_x_q[c] <= XW'(s2_val_q) * XW'(s2_a_q[c]);
    end
  end

  // stage 4: truncating divide by the common scale, reciprocal is exact here
  logic [PW-1:0] s4_prod [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      s4_prod[c] = PW'(s3_x_q[c]) * PW'(hsv2rgb_pkg::RecipMult);
    end
  end

  logic [IdxW-1:0]      s4_index_q;
  logic [FW-1:0]        s4_val_q;
  hsv2rgb_pkg::sector_e s4_sec_q;
  logic [CW-1:0]        s4_ch_q [NC];

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_index_q <= s3_index_q;
      s4_val_q   <= s3_val_q;
      s4_sec_q   <= s3_sec_q;
      for (int c = 0; c < NC; c++) begin
        s4_ch_q[c] <= s4_prod[c][hsv2rgb_pkg::RecipShift+CW-1:hsv2rgb_pkg::RecipShift];
      end
    end
  end

  // stage 5: six-way channel assignment
  logic [CW-1:0] red_d, green_d, blue_d;
  logic [CW-1:0] tp, tq, tt;

  always_comb begin
    tp = s4_ch_q[hsv2rgb_pkg::ChP];
    tq = s4_ch_q[hsv2rgb_pkg::ChQ];
    tt = s4_ch_q[hsv2rgb_pkg::ChT];
    unique case (s4_sec_q)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_d = s4_val_q; green_d = tt;       blue_d = tp;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_d = tq;       green_d = s4_val_q; blue_d = tp;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_d = tp;       green_d = s4_val_q; blue_d = tt;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_d = tp;       green_d = tq;       blue_d = s4_val_q;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_d = tt;       green_d = tp;       blue_d = s4_val_q;
      end
      default: begin
        red_d = s4_val_q; green_d = tp;       blue_d = tq;
      end
    endcase
  end

  logic [hsv2rgb_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_data_q <= hsv2rgb_pkg::OutDataW'({blue_d, green_d, red_d, s4_index_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
